// File: src/tpsd_pkg.sv
`timescale 1ns / 1ps
package tpsd_pkg;

	localparam int MaxWidthDef = 1024;
	localparam int MaxHeightDef = 1024;
	localparam int PaletteDepthDef = 256;

	localparam logic [31:0] AlphaOpaque = 32'hFF000000;
	localparam logic [31:0] Rgb24Mask = 32'h00FFFFFF;
	localparam logic [15:0] Chan5Lo = 16'h001F;
	localparam logic [15:0] Chan5Mid = 16'h03E0;
	localparam logic [15:0] Chan5Hi = 16'h7C00;
	localparam logic [7:0] RunFlag = 8'h80;
	localparam logic [7:0] CountMask = 8'h7F;
	localparam int DivSteps = 32;

	typedef enum logic [2:0] {
		REG_WIDTH = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_PIXEL_BITS = 3'd2,
		REG_IMAGE_TYPE = 3'd3,
		REG_TOP_ORIGIN = 3'd4,
		REG_CMAP_LENGTH = 3'd5,
		REG_CMAP_BITS = 3'd6,
		REG_CMAP_OFFSET = 3'd7
	} tpsd_reg_t;

	typedef enum logic [1:0] {
		PH_PALETTE,
		PH_HEADER,
		PH_PIXEL,
		PH_DONE
	} tpsd_phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_INDEX,
		BK_READ,
		BK_FIN
	} tpsd_bstate_t;

	typedef struct packed {
		logic [10:0] image_width;
		logic [10:0] image_height;
		logic [5:0] pixel_bits;
		logic [3:0] image_type;
		logic top_origin;
		logic [8:0] cmap_length;
		logic [5:0] cmap_bits;
		logic [7:0] cmap_offset;
	} tpsd_cfg_t;

	typedef struct packed {
		logic [19:0] addr;
		logic [31:0] value;
		logic [7:0] len;
		logic done;
		logic cmap;
	} tpsd_job_t;

	function automatic logic [2:0] bytes_for(input logic [5:0] bits);
		logic [2:0] n;
		begin
			if (bits == 6'd0) n = 3'd1;
			else if (bits > 6'd32) n = 3'd4;
			else n = 3'(((bits - 6'd1) >> 3) + 6'd1);
			return n;
		end
	endfunction

	function automatic logic [31:0] to_argb(input logic [31:0] v, input logic [5:0] bits);
		logic [31:0] c;
		begin
			unique case (bits)
				6'd16: c = (v[15] ? AlphaOpaque : 32'd0)
					| ({16'd0, v[15:0] & Chan5Lo} << 3)
					| ({16'd0, v[15:0] & Chan5Mid} << 6)
					| ({16'd0, v[15:0] & Chan5Hi} << 9);
				6'd24: c = AlphaOpaque | (v & Rgb24Mask);
				6'd32: c = v;
				default: c = AlphaOpaque;
			endcase
			return c;
		end
	endfunction

endpackage

// File: src/tga_pixel_stream_decoder_core.sv
`timescale 1ns / 1ps
// input: one byte per cycle while full is low; a non-colour-mapped pixel passes the job
// queue, back-end job register and output register. colour-mapped pixels go through a
// modulo divider and a registered palette read; a 4-entry job queue buffers the front.
// palette bytes are held off while earlier pixels are still in the back end.
// arst_n clears parser, queue and output valid; the palette memory is not cleared.
module tga_pixel_stream_decoder_core #(
	parameter int MAX_WIDTH = tpsd_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = tpsd_pkg::MaxHeightDef,
	parameter int PALETTE_DEPTH = tpsd_pkg::PaletteDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic start_of_image,
	output logic empty,
	input logic pop,
	output logic [19:0] pixel_address,
	output logic [31:0] pixel_color,
	output logic [7:0] run_length,
	output logic index_error,
	output logic image_done,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	import tpsd_pkg::*;

	localparam int Aw = $clog2(PALETTE_DEPTH);

	tpsd_cfg_t cfg_q;
	tpsd_job_t job_in, job_out;
	logic job_wr, job_rd, job_full, job_empty, busy;
	logic pal_we, pal_re;
	logic [Aw-1:0] pal_waddr, pal_raddr;
	logic [31:0] pal_wdata, pal_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width <= 11'd1;
			cfg_q.image_height <= 11'd1;
			cfg_q.pixel_bits <= 6'd32;
			cfg_q.image_type <= 4'd2;
			cfg_q.top_origin <= 1'b0;
			cfg_q.cmap_length <= 9'd0;
			cfg_q.cmap_bits <= 6'd24;
			cfg_q.cmap_offset <= 8'd0;
		end else if (cfg_valid) begin
			unique case (tpsd_reg_t'(cfg_index))
				REG_WIDTH: cfg_q.image_width <= cfg_data[10:0];
				REG_HEIGHT: cfg_q.image_height <= cfg_data[10:0];
				REG_PIXEL_BITS: cfg_q.pixel_bits <= cfg_data[5:0];
				REG_IMAGE_TYPE: cfg_q.image_type <= cfg_data[3:0];
				REG_TOP_ORIGIN: cfg_q.top_origin <= cfg_data[0];
				REG_CMAP_LENGTH: cfg_q.cmap_length <= cfg_data[8:0];
				REG_CMAP_BITS: cfg_q.cmap_bits <= cfg_data[5:0];
				REG_CMAP_OFFSET: cfg_q.cmap_offset <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tpsd_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk, .arst_n, .cfg(cfg_q), .push, .data_byte, .start_of_image, .full,
		.drain_busy(busy), .job_full, .job_wr, .job(job_in),
		.pal_we, .pal_waddr, .pal_wdata
	);

	tpsd_fifo u_fifo (
		.clk, .arst_n, .wr(job_wr), .wdata(job_in), .rd(job_rd), .rdata(job_out),
		.full(job_full), .empty(job_empty)
	);

	tpsd_ram #(.Width(32), .Depth(PALETTE_DEPTH)) u_pal (
		.clk, .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
		.re(pal_re), .raddr(pal_raddr), .rdata(pal_rdata)
	);

	tpsd_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .job_empty, .job(job_out), .job_rd,
		.pal_re, .pal_raddr, .pal_rdata, .pop, .empty, .busy,
		.pixel_address, .pixel_color, .run_length, .index_error, .image_done
	);
endmodule

// File: src/tpsd_ram.sv
`timescale 1ns / 1ps
module tpsd_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic re,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// File: src/tpsd_fifo.sv
`timescale 1ns / 1ps
module tpsd_fifo (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input tpsd_pkg::tpsd_job_t wdata,
	input logic rd,
	output tpsd_pkg::tpsd_job_t rdata,
	output logic full,
	output logic empty
);
	import tpsd_pkg::*;

	tpsd_job_t slot_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) slot_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 2'd1;
			if (rd && !empty) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr && !full) - 3'(rd && !empty);
		end
	end
endmodule

// File: src/tpsd_front.sv
`timescale 1ns / 1ps
module tpsd_front #(
	parameter int MAX_WIDTH = tpsd_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = tpsd_pkg::MaxHeightDef,
	parameter int PALETTE_DEPTH = tpsd_pkg::PaletteDepthDef
) (
	input logic clk,
	input logic arst_n,
	input tpsd_pkg::tpsd_cfg_t cfg,
	input logic push,
	input logic [7:0] data_byte,
	input logic start_of_image,
	output logic full,
	input logic drain_busy,
	input logic job_full,
	output logic job_wr,
	output tpsd_pkg::tpsd_job_t job,
	output logic pal_we,
	output logic [$clog2(PALETTE_DEPTH)-1:0] pal_waddr,
	output logic [31:0] pal_wdata
);
	import tpsd_pkg::*;

	localparam int Aw = $clog2(PALETTE_DEPTH);
	localparam logic [10:0] WMax = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);
	localparam logic [10:0] HMax = (MAX_HEIGHT > 2047) ? 11'd2047 : 11'(MAX_HEIGHT);

	tpsd_phase_t phase_q, phase_d;
	logic [1:0] bidx_q, bidx_d;
	logic [31:0] asm_q, asm_d;
	logic [7:0] prem_q, prem_d;
	logic run_q, run_d;
	logic [10:0] col_q, col_d, rows_q, rows_d;
	logic [8:0] fill_q, fill_d;
	logic accept;

	assign full = job_full | (drain_busy & (phase_q == PH_PALETTE | start_of_image));
	assign accept = push & ~full;

	always_comb begin
		tpsd_phase_t ph;
		logic [1:0] bi;
		logic [31:0] ca;
		logic [7:0] pr;
		logic rn;
		logic [10:0] col, rows, w, h, c0, r, row, n, ln;
		logic [8:0] fill;
		logic [2:0] nb;
		logic complete, go;
		logic [21:0] prod;
		logic [7:0] len;
		logic [31:0] color;

		ph = phase_q; bi = bidx_q; ca = asm_q; pr = prem_q; rn = run_q;
		col = col_q; rows = rows_q; fill = fill_q;
		pal_we = 1'b0; pal_waddr = '0; pal_wdata = '0;
		job_wr = 1'b0; job = '0;
		complete = 1'b0; go = 1'b1; nb = 3'd1;
		w = '0; h = '0; c0 = '0; r = '0; row = '0; n = '0; ln = '0; prod = '0;
		len = 8'd1; color = '0;

		if (accept) begin
			if (start_of_image) begin
				ph = PH_PALETTE; bi = '0; ca = '0; pr = '0; rn = 1'b0;
				col = '0; rows = '0; fill = '0;
			end
			if (ph == PH_DONE) go = 1'b0;
			if (go && ph == PH_PALETTE) begin
				if (fill < cfg.cmap_length) begin
					nb = bytes_for(cfg.cmap_bits);
					ca = ca | ({24'd0, data_byte} << {bi, 3'b000});
					if ({1'b0, bi} + 3'd1 >= nb) begin
						bi = '0;
						if (32'(fill) < PALETTE_DEPTH) begin
							pal_we = 1'b1;
							pal_waddr = Aw'(fill);
							pal_wdata = to_argb(ca, cfg.cmap_bits);
						end
						ca = '0;
						fill = fill + 9'd1;
					end else bi = bi + 2'd1;
					go = 1'b0;
				end else begin
					ph = cfg.image_type[3] ? PH_HEADER : PH_PIXEL;
					bi = '0; ca = '0;
				end
			end
			if (go && ph == PH_HEADER) begin
				rn = (data_byte & RunFlag) != 8'd0;
				pr = (data_byte & CountMask) + 8'd1;
				ph = PH_PIXEL; bi = '0; ca = '0;
				go = 1'b0;
			end
			if (go) begin
				nb = bytes_for(cfg.pixel_bits);
				ca = ca | ({24'd0, data_byte} << {bi, 3'b000});
				if ({1'b0, bi} + 3'd1 >= nb) begin
					bi = '0;
					complete = 1'b1;
				end else bi = bi + 2'd1;
			end
			if (complete) begin
				color = (cfg.image_type[2:0] == 3'd1) ? ca : to_argb(ca, cfg.pixel_bits);
				ca = '0;
				if (cfg.image_type[3]) begin
					if (rn) begin
						len = (pr == 8'd0) ? 8'd1 : pr;
						pr = '0;
					end else if (pr != 8'd0) pr = pr - 8'd1;
					if (pr == 8'd0) ph = PH_HEADER;
				end
				// geometry of this beat
				w = (cfg.image_width == 11'd0) ? 11'd1
					: (cfg.image_width > WMax ? WMax : cfg.image_width);
				h = (cfg.image_height == 11'd0) ? 11'd1
					: (cfg.image_height > HMax ? HMax : cfg.image_height);
				c0 = (col >= w) ? w - 11'd1 : col;
				r = (rows >= h) ? h - 11'd1 : rows;
				row = cfg.top_origin ? r : h - 11'd1 - r;
				n = w - c0;
				ln = {3'd0, len};
				if (ln < n) n = ln;
				if (n == 11'd0) n = 11'd1;
				prod = row * w;
				job.addr = prod[19:0] + {9'd0, c0};
				job.value = color;
				job.len = n[7:0];
				job.cmap = cfg.image_type[2:0] == 3'd1;
				col = c0 + n;
				if (col >= w) begin
					col = '0;
					rows = rows + 11'd1;
					if (rows >= h) begin
						ph = PH_DONE;
						job.done = 1'b1;
					end
				end
				job_wr = 1'b1;
			end
		end
		phase_d = ph; bidx_d = bi; asm_d = ca; prem_d = pr; run_d = rn;
		col_d = col; rows_d = rows; fill_d = fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PALETTE;
			bidx_q <= '0;
			asm_q <= '0;
			prem_q <= '0;
			run_q <= 1'b0;
			col_q <= '0;
			rows_q <= '0;
			fill_q <= '0;
		end else begin
			phase_q <= phase_d;
			bidx_q <= bidx_d;
			asm_q <= asm_d;
			prem_q <= prem_d;
			run_q <= run_d;
			col_q <= col_d;
			rows_q <= rows_d;
			fill_q <= fill_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) job_wr |-> !pal_we)
		else $error("palette write and pixel job in one beat");
	assert property (@(posedge clk) disable iff (!arst_n) pal_we |-> !drain_busy)
		else $error("palette written while lookups pending");
	assert property (@(posedge clk) disable iff (!arst_n) job_wr |-> job.len != 8'd0)
		else $error("zero run length");
endmodule

// File: src/tpsd_back.sv
`timescale 1ns / 1ps
module tpsd_back #(
	parameter int PALETTE_DEPTH = tpsd_pkg::PaletteDepthDef
) (
	input logic clk,
	input logic arst_n,
	input tpsd_pkg::tpsd_cfg_t cfg,
	input logic job_empty,
	input tpsd_pkg::tpsd_job_t job,
	output logic job_rd,
	output logic pal_re,
	output logic [$clog2(PALETTE_DEPTH)-1:0] pal_raddr,
	input logic [31:0] pal_rdata,
	input logic pop,
	output logic empty,
	output logic busy,
	output logic [19:0] pixel_address,
	output logic [31:0] pixel_color,
	output logic [7:0] run_length,
	output logic index_error,
	output logic image_done
);
	import tpsd_pkg::*;

	localparam int Aw = $clog2(PALETTE_DEPTH);

	tpsd_bstate_t state_q, state_d;
	tpsd_job_t cur_q;
	logic [31:0] div_q;
	logic [8:0] rem_q;
	logic [4:0] cnt_q;
	logic [31:0] color_q;
	logic err_q;
	logic out_v_q;
	logic [9:0] shifted, idx;
	logic bad_idx, load_out;

	assign shifted = {rem_q, div_q[31]};
	assign idx = {1'b0, rem_q} + {2'd0, cfg.cmap_offset};
	assign bad_idx = idx >= {1'b0, cfg.cmap_length} || 32'(idx) >= PALETTE_DEPTH;
	assign load_out = state_q == BK_FIN && (!out_v_q || pop);
	assign job_rd = state_q == BK_IDLE && !job_empty;
	assign pal_re = state_q == BK_INDEX && !bad_idx;
	assign pal_raddr = Aw'(idx);
	assign empty = !out_v_q;
	assign busy = out_v_q || !job_empty || state_q != BK_IDLE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!job_empty)
				state_d = (job.cmap && cfg.cmap_length != 9'd0) ? BK_DIV : BK_FIN;
			BK_DIV: if (cnt_q == 5'(DivSteps - 1)) state_d = BK_INDEX;
			BK_INDEX: state_d = bad_idx ? BK_FIN : BK_READ;
			BK_READ: state_d = BK_FIN;
			BK_FIN: if (!out_v_q || pop) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_rd) begin
			cur_q <= job;
			div_q <= job.value;
			rem_q <= '0;
			cnt_q <= '0;
			color_q <= job.cmap ? 32'd0 : job.value;
			err_q <= job.cmap;
		end
		if (state_q == BK_DIV) begin
			// restoring division, one quotient bit per beat
			rem_q <= (shifted >= {1'b0, cfg.cmap_length})
				? 9'(shifted - {1'b0, cfg.cmap_length}) : shifted[8:0];
			div_q <= {div_q[30:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
		end
		if (state_q == BK_INDEX) err_q <= bad_idx;
		if (state_q == BK_READ) color_q <= pal_rdata;
		if (load_out) begin
			pixel_address <= cur_q.addr;
			pixel_color <= color_q;
			run_length <= cur_q.len;
			index_error <= err_q;
			image_done <= cur_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV |-> cfg.cmap_length != 9'd0)
		else $error("division by empty map");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV && cnt_q != 5'(DivSteps - 1) |=> state_q == BK_DIV)
		else $error("division cut short");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_FIN && err_q |-> color_q == 32'd0)
		else $error("index error with nonzero color");
endmodule
